// ===== sv/tha_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the track
// acceptance check. No dependencies.
`timescale 1ns / 1ps
package tha_pkg;

   // CORDIC depth and datapath widths
   localparam int CORDIC_STEPS = 20;
   localparam int VEC_W        = 48;   // vectoring x/y, millimetres scaled by 2^20
   localparam int ROT_W        = 33;   // rotation x/y, Q30
   localparam int ANGZ_W       = 32;   // CORDIC angle accumulator, 2^-32 turn
   localparam int ANG_W        = 18;   // binary angle units with headroom
   localparam int MAG_W        = 21;   // Q20 magnitude, 0..2^20
   localparam int LEN_W        = 23;   // configured lengths
   localparam int DIF_W        = 26;   // position differences
   localparam int DIST_W       = 24;   // side distance

   localparam logic signed [ANG_W-1:0] ANG_ZERO       = 18'sd0;
   localparam logic signed [ANG_W-1:0] ANG_HALFPI     = 18'sd16384;
   localparam logic signed [ANG_W-1:0] ANG_PI         = 18'sd32768;
   localparam logic signed [ANG_W-1:0] ANG_NEG_HALFPI = -18'sd16384;

   localparam logic [MAG_W-1:0]        Q20_ONE        = 21'd1048576;
   localparam logic signed [ROT_W-1:0] CORDIC_GAIN_INV = 33'sd652032874;

   localparam logic [LEN_W-1:0] X_HALF_RESET  = 23'd12000;
   localparam logic [LEN_W-1:0] Y_HALF_RESET  = 23'd12000;
   localparam logic [LEN_W-1:0] VTRAVEL_RESET = 23'd19000;

   // register map
   typedef enum logic [1:0] {
      CSR_X_HALF  = 2'd0,
      CSR_Y_HALF  = 2'd1,
      CSR_VTRAVEL = 2'd2
   } tha_csr_type;

   // result causes
   typedef enum logic [1:0] {
      CAUSE_ACCEPT  = 2'd0,
      CAUSE_AZIMUTH = 2'd1,
      CAUSE_STEEP   = 2'd2
   } tha_cause_type;

   // sin/cos operands that land exactly on an axis bypass the CORDIC
   typedef enum logic [1:0] {
      TRIG_NORMAL,
      TRIG_ZERO,
      TRIG_QUARTER
   } tha_trig_kind_type;

   typedef struct packed {
      logic signed [23:0] x_position;
      logic signed [23:0] y_position;
      logic [14:0]        zenith;
      logic signed [15:0] azimuth;
   } tha_req_type;

   typedef struct packed {
      logic       rejected;
      logic [1:0] reject_cause;
   } tha_rsp_type;

   // per atan2 lane: exact result flag and fold angle
   typedef struct packed {
      logic                    exact;
      logic signed [ANG_W-1:0] base;
   } tha_vlane_type;

   // item data riding alongside the CORDIC lanes
   typedef struct packed {
      logic                     x_lo;
      logic                     x_hi;
      logic                     y_lo;
      logic                     y_hi;
      logic [DIST_W-1:0]        dist_x;
      logic [DIST_W-1:0]        dist_y;
      logic signed [15:0]       azimuth;
      tha_trig_kind_type        kind_zen;
      tha_trig_kind_type        kind_az;
      tha_vlane_type [3:0]      vlane;
   } tha_side_type;

   // angle test outcome carried to the final stage
   typedef struct packed {
      logic out_x;
      logic out_y;
      logic rej_x;
      logic rej_y;
   } tha_flags_type;

   // atan(2^-i) in 2^-32 turn
   function automatic logic signed [ANGZ_W-1:0] atan_turn(input logic [4:0] idx);
      logic signed [ANGZ_W-1:0] r;
      begin
         case (idx)
            5'd0:    r = 32'sd536870912;
            5'd1:    r = 32'sd316933406;
            5'd2:    r = 32'sd167458907;
            5'd3:    r = 32'sd85004756;
            5'd4:    r = 32'sd42667331;
            5'd5:    r = 32'sd21354465;
            5'd6:    r = 32'sd10679838;
            5'd7:    r = 32'sd5340245;
            5'd8:    r = 32'sd2670163;
            5'd9:    r = 32'sd1335087;
            5'd10:   r = 32'sd667544;
            5'd11:   r = 32'sd333772;
            5'd12:   r = 32'sd166886;
            5'd13:   r = 32'sd83443;
            5'd14:   r = 32'sd41722;
            5'd15:   r = 32'sd20861;
            5'd16:   r = 32'sd10430;
            5'd17:   r = 32'sd5215;
            5'd18:   r = 32'sd2608;
            5'd19:   r = 32'sd1304;
            default: r = 32'sd0;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== sv/tha_vec_pipe.sv =====
// Pipelined CORDIC vectoring lane: one iteration per register stage,
// accumulates the angle of (x, y). Depends on tha_pkg.
`timescale 1ns / 1ps
module tha_vec_pipe import tha_pkg::*; (
   input  logic                     clock,
   input  logic signed [VEC_W-1:0]  init_x,
   input  logic signed [VEC_W-1:0]  init_y,
   output logic signed [ANGZ_W-1:0] angle_z
);

   logic signed [VEC_W-1:0]  x_ff [CORDIC_STEPS+1];
   logic signed [VEC_W-1:0]  y_ff [CORDIC_STEPS+1];
   logic signed [ANGZ_W-1:0] z_ff [CORDIC_STEPS+1];

   // load stage
   always_ff @(posedge clock) begin
      x_ff[0] <= init_x;
      y_ff[0] <= init_y;
      z_ff[0] <= '0;
   end

   // one micro-rotation per stage, driving y toward zero
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic signed [VEC_W-1:0]  xs, ys, x_in, y_in;
      logic signed [ANGZ_W-1:0] z_in;

      always_comb begin
         xs = x_ff[k] >>> k;
         ys = y_ff[k] >>> k;
         if (y_ff[k] > 0) begin
            x_in = x_ff[k] + ys;
            y_in = y_ff[k] - xs;
            z_in = z_ff[k] + atan_turn(5'(k));
         end else begin
            x_in = x_ff[k] - ys;
            y_in = y_ff[k] + xs;
            z_in = z_ff[k] - atan_turn(5'(k));
         end
      end

      always_ff @(posedge clock) begin
         x_ff[k+1] <= x_in;
         y_ff[k+1] <= y_in;
         z_ff[k+1] <= z_in;
      end
   end

   assign angle_z = z_ff[CORDIC_STEPS];

endmodule

// ===== sv/tha_rot_pipe.sv =====
// Pipelined CORDIC rotation lane: one iteration per register stage,
// gives cos and sin in Q30. Depends on tha_pkg.
`timescale 1ns / 1ps
module tha_rot_pipe import tha_pkg::*; (
   input  logic                     clock,
   input  logic signed [ANGZ_W-1:0] init_z,
   output logic signed [ROT_W-1:0]  cos_q30,
   output logic signed [ROT_W-1:0]  sin_q30
);

   logic signed [ROT_W-1:0]  x_ff [CORDIC_STEPS+1];
   logic signed [ROT_W-1:0]  y_ff [CORDIC_STEPS+1];
   logic signed [ANGZ_W-1:0] z_ff [CORDIC_STEPS+1];

   // load stage, starting from the inverse gain on the x axis
   always_ff @(posedge clock) begin
      x_ff[0] <= CORDIC_GAIN_INV;
      y_ff[0] <= '0;
      z_ff[0] <= init_z;
   end

   // one micro-rotation per stage, driving z toward zero
   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
      logic signed [ROT_W-1:0]  xs, ys, x_in, y_in;
      logic signed [ANGZ_W-1:0] z_in;

      always_comb begin
         xs = x_ff[k] >>> k;
         ys = y_ff[k] >>> k;
         if (z_ff[k] >= 0) begin
            x_in = x_ff[k] - ys;
            y_in = y_ff[k] + xs;
            z_in = z_ff[k] - atan_turn(5'(k));
         end else begin
            x_in = x_ff[k] + ys;
            y_in = y_ff[k] - xs;
            z_in = z_ff[k] + atan_turn(5'(k));
         end
      end

      always_ff @(posedge clock) begin
         x_ff[k+1] <= x_in;
         y_ff[k+1] <= y_in;
         z_ff[k+1] <= z_in;
      end
   end

   assign cos_q30 = x_ff[CORDIC_STEPS];
   assign sin_q30 = y_ff[CORDIC_STEPS];

endmodule

// ===== sv/tha_reach.sv =====
// Three-stage reach test: travel*sin(z)*|c| against d*cos(z)*2^20 for the
// x and y sides. Depends on tha_pkg.
`timescale 1ns / 1ps
module tha_reach import tha_pkg::*; (
   input  logic              clock,
   input  logic [LEN_W-1:0]  travel,
   input  logic [MAG_W-1:0]  sin_zen,
   input  logic [MAG_W-1:0]  cos_zen,
   input  logic [MAG_W-1:0]  cos_az,
   input  logic [MAG_W-1:0]  sin_az,
   input  logic [DIST_W-1:0] dist_x,
   input  logic [DIST_W-1:0] dist_y,
   output logic              steep_x,
   output logic              steep_y
);

   logic [43:0]      m1_ff, m1_in;
   logic [44:0]      mx1_ff, mx1_in, my1_ff, my1_in;
   logic [MAG_W-1:0] ca1_ff, sa1_ff;
   logic [42:0]      plx_ff, plx_in, phx_ff, phx_in, ply_ff, ply_in, phy_ff, phy_in;
   logic [44:0]      mx2_ff, my2_ff;
   logic [65:0]      lhs_x, lhs_y, rhs_x, rhs_y;
   logic             steep_x_ff, steep_y_ff;

   // stage 1: travel*sin(z), distance*cos(z)
   always_comb begin
      m1_in  = 44'(travel) * 44'(sin_zen);
      mx1_in = 45'(dist_x) * 45'(cos_zen);
      my1_in = 45'(dist_y) * 45'(cos_zen);
   end

   always_ff @(posedge clock) begin
      m1_ff  <= m1_in;
      mx1_ff <= mx1_in;
      my1_ff <= my1_in;
      ca1_ff <= cos_az;
      sa1_ff <= sin_az;
   end

   // stage 2: split the 44-bit product into two 22-bit halves
   always_comb begin
      plx_in = 43'(m1_ff[21:0])  * 43'(ca1_ff);
      phx_in = 43'(m1_ff[43:22]) * 43'(ca1_ff);
      ply_in = 43'(m1_ff[21:0])  * 43'(sa1_ff);
      phy_in = 43'(m1_ff[43:22]) * 43'(sa1_ff);
   end

   always_ff @(posedge clock) begin
      plx_ff <= plx_in;
      phx_ff <= phx_in;
      ply_ff <= ply_in;
      phy_ff <= phy_in;
      mx2_ff <= mx1_ff;
      my2_ff <= my1_ff;
   end

   // stage 3: recombine and compare
   always_comb begin
      lhs_x = (66'(phx_ff) << 22) + 66'(plx_ff);
      lhs_y = (66'(phy_ff) << 22) + 66'(ply_ff);
      rhs_x = {1'b0, mx2_ff, 20'd0};
      rhs_y = {1'b0, my2_ff, 20'd0};
   end

   always_ff @(posedge clock) begin
      steep_x_ff <= lhs_x < rhs_x;
      steep_y_ff <= lhs_y < rhs_y;
   end

   assign steep_x = steep_x_ff;
   assign steep_y = steep_y_ff;

endmodule

// ===== sv/track_hall_acceptance_check.sv =====
// Top level of the track acceptance check: input stage, four atan2 lanes,
// two sin/cos lanes, angle tests and reach test. Depends on tha_pkg,
// tha_vec_pipe, tha_rot_pipe and tha_reach.
// Path: an accepted word passes the input stage, the CORDIC load stage, 20
// CORDIC stages and 5 post stages to rsp_word; rsp_strobe marks it.
// Throughput: one word per cycle unless busy; fully pipelined, the receiver cannot stall.
// Reset: synchronous; clears the pipeline valid bits, loads the registers
// with their defaults and holds busy high for the cycle after reset.
`timescale 1ns / 1ps
module track_hall_acceptance_check import tha_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tha_req_type       req_word,
   output logic              rsp_strobe,
   output tha_rsp_type       rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [LEN_W-1:0]  csr_wdata
);

   localparam int LANES   = 4;
   localparam int LANE_A  = 0;   // (Y - yp, -X - xp)
   localparam int LANE_B  = 1;   // (-Y - yp, -X - xp)
   localparam int LANE_C  = 2;   // (Y - yp, X - xp)
   localparam int LANE_D  = 3;   // (-Y - yp, X - xp)
   localparam int LATENCY = CORDIC_STEPS + 7;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      tha_vlane_type           lane;
   } tha_vinit_type;

   typedef struct packed {
      logic signed [ANGZ_W-1:0] z;
      tha_trig_kind_type        kind;
   } tha_tinit_type;

   // atan2 setup: axis cases, quarter-turn fold, scale by 2^20
   function automatic tha_vinit_type vec_init(input logic signed [DIF_W-1:0] dy,
                                              input logic signed [DIF_W-1:0] dx);
      tha_vinit_type r;
      logic signed [DIF_W-1:0] fx, fy;
      begin
         fx = dx;
         fy = dy;
         r.lane.exact = 1'b0;
         r.lane.base  = ANG_ZERO;
         if (dy == 0) begin
            r.lane.exact = 1'b1;
            r.lane.base  = (dx < 0) ? ANG_PI : ANG_ZERO;
         end else if (dx == 0) begin
            r.lane.exact = 1'b1;
            r.lane.base  = (dy > 0) ? ANG_HALFPI : ANG_NEG_HALFPI;
         end else if (dx < 0) begin
            if (dy > 0) begin
               fx = dy;
               fy = -dx;
               r.lane.base = ANG_HALFPI;
            end else begin
               fx = -dy;
               fy = dx;
               r.lane.base = ANG_NEG_HALFPI;
            end
         end
         r.x = {{(VEC_W-DIF_W-20){fx[DIF_W-1]}}, fx, 20'd0};
         r.y = {{(VEC_W-DIF_W-20){fy[DIF_W-1]}}, fy, 20'd0};
         return r;
      end
   endfunction

   // sin/cos setup: fold into [-pi/2, pi/2], flag exact axis angles
   function automatic tha_tinit_type trig_init(input logic signed [16:0] a);
      tha_tinit_type r;
      logic signed [16:0] af;
      begin
         if (a > 17'sd16384) begin
            af = a - 17'sd32768;
         end else if (a < -17'sd16384) begin
            af = a + 17'sd32768;
         end else begin
            af = a;
         end
         if (af == 17'sd0) begin
            r.kind = TRIG_ZERO;
         end else if (af == 17'sd16384 || af == -17'sd16384) begin
            r.kind = TRIG_QUARTER;
         end else begin
            r.kind = TRIG_NORMAL;
         end
         r.z = {af[15:0], 16'd0};
         return r;
      end
   endfunction

   // Q30 to rounded, absolute, clamped Q20
   function automatic logic [MAG_W-1:0] mag20(input logic signed [ROT_W-1:0] q);
      logic signed [ROT_W:0] t;
      logic signed [23:0]    r;
      logic [23:0]           m;
      begin
         t = {q[ROT_W-1], q} + 34'sd512;
         r = t[ROT_W:10];
         m = (r < 0) ? 24'(-r) : 24'(r);
         return (m > 24'(Q20_ONE)) ? Q20_ONE : m[MAG_W-1:0];
      end
   endfunction

   // CORDIC angle to binary angle units plus fold angle
   function automatic logic signed [ANG_W-1:0] vec_angle(
      input logic signed [ANGZ_W-1:0] z, input tha_vlane_type lane);
      logic signed [ANGZ_W:0] zz;
      logic signed [16:0]     q;
      begin
         zz = {z[ANGZ_W-1], z} + 33'sd32768;
         q  = zz[ANGZ_W:16];
         return lane.exact ? lane.base : (18'(q) + lane.base);
      end
   endfunction

   // ---------------------------------------------------------------
   // configuration registers
   logic [LEN_W-1:0] x_half_ff, y_half_ff, vtravel_ff;
   logic             busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_half_ff  <= X_HALF_RESET;
         y_half_ff  <= Y_HALF_RESET;
         vtravel_ff <= VTRAVEL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (tha_csr_type'(csr_index))
            CSR_X_HALF:  x_half_ff  <= csr_wdata;
            CSR_Y_HALF:  y_half_ff  <= csr_wdata;
            CSR_VTRAVEL: vtravel_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy = busy_ff;

   // ---------------------------------------------------------------
   // input stage
   logic        in_vld_ff;
   tha_req_type in_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start && !busy;
      end
      in_word_ff <= req_word;
   end

   // ---------------------------------------------------------------
   // setup: differences, side flags, lane inits
   logic signed [DIF_W-1:0] xp, yp, xh, yh, dxn, dxp, dyp, dyn, dxm, dym;
   logic signed [16:0]      zen_a, az_a;
   tha_vinit_type           vinit [LANES];
   tha_tinit_type           tinit_zen, tinit_az;
   tha_side_type            side_in;

   always_comb begin
      xp  = {{(DIF_W-24){in_word_ff.x_position[23]}}, in_word_ff.x_position};
      yp  = {{(DIF_W-24){in_word_ff.y_position[23]}}, in_word_ff.y_position};
      xh  = {{(DIF_W-LEN_W){1'b0}}, x_half_ff};
      yh  = {{(DIF_W-LEN_W){1'b0}}, y_half_ff};
      dxn = -xh - xp;
      dxp = xh - xp;
      dyp = yh - yp;
      dyn = -yh - yp;
      dxm = xp - xh;
      dym = yp - yh;

      vinit[LANE_A] = vec_init(dyp, dxn);
      vinit[LANE_B] = vec_init(dyn, dxn);
      vinit[LANE_C] = vec_init(dyp, dxp);
      vinit[LANE_D] = vec_init(dyn, dxp);

      // zenith past horizontal saturates to pi/2
      zen_a = (in_word_ff.zenith > 15'd16384) ? 17'sd16384 : {2'b00, in_word_ff.zenith};
      az_a  = {in_word_ff.azimuth[15], in_word_ff.azimuth};
      tinit_zen = trig_init(zen_a);
      tinit_az  = trig_init(az_a);

      side_in.x_lo     = xp < -xh;
      side_in.x_hi     = xp > xh;
      side_in.y_lo     = yp < -yh;
      side_in.y_hi     = yp > yh;
      side_in.dist_x   = side_in.x_lo ? dxn[DIST_W-1:0] : dxm[DIST_W-1:0];
      side_in.dist_y   = side_in.y_lo ? dyn[DIST_W-1:0] : dym[DIST_W-1:0];
      side_in.azimuth  = in_word_ff.azimuth;
      side_in.kind_zen = tinit_zen.kind;
      side_in.kind_az  = tinit_az.kind;
      for (int i = 0; i < LANES; i++) begin
         side_in.vlane[i] = vinit[i].lane;
      end
   end

   // ---------------------------------------------------------------
   // CORDIC lanes with matching valid and side delay lines
   logic signed [ANGZ_W-1:0] lane_z [LANES];
   logic signed [ROT_W-1:0]  zen_cos, zen_sin, az_cos, az_sin;
   logic                     cv_ff   [CORDIC_STEPS+1];
   tha_side_type             side_ff [CORDIC_STEPS+1];

   for (genvar l = 0; l < LANES; l++) begin : g_vec
      tha_vec_pipe u_vec (
         .clock   (clock),
         .init_x  (vinit[l].x),
         .init_y  (vinit[l].y),
         .angle_z (lane_z[l])
      );
   end

   tha_rot_pipe u_rot_zen (
      .clock   (clock),
      .init_z  (tinit_zen.z),
      .cos_q30 (zen_cos),
      .sin_q30 (zen_sin)
   );

   tha_rot_pipe u_rot_az (
      .clock   (clock),
      .init_z  (tinit_az.z),
      .cos_q30 (az_cos),
      .sin_q30 (az_sin)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= CORDIC_STEPS; k++) begin
            cv_ff[k] <= 1'b0;
         end
      end else begin
         cv_ff[0] <= in_vld_ff;
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            cv_ff[k+1] <= cv_ff[k];
         end
      end
      side_ff[0] <= side_in;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         side_ff[k+1] <= side_ff[k];
      end
   end

   // ---------------------------------------------------------------
   // post stage 1: angles and magnitudes
   tha_side_type            sd;
   logic signed [ANG_W-1:0] ang_in [LANES];
   logic [MAG_W-1:0]        cz_in, sz_in, ca_in, sa_in;

   logic                    p1_vld_ff;
   tha_side_type            p1_side_ff;
   logic signed [ANG_W-1:0] p1_ang_ff [LANES];
   logic [MAG_W-1:0]        p1_cz_ff, p1_sz_ff, p1_ca_ff, p1_sa_ff;

   always_comb begin
      sd = side_ff[CORDIC_STEPS];
      for (int i = 0; i < LANES; i++) begin
         ang_in[i] = vec_angle(lane_z[i], sd.vlane[i]);
      end
      unique case (sd.kind_zen)
         TRIG_ZERO: begin
            cz_in = Q20_ONE;
            sz_in = '0;
         end
         TRIG_QUARTER: begin
            cz_in = '0;
            sz_in = Q20_ONE;
         end
         default: begin
            cz_in = mag20(zen_cos);
            sz_in = mag20(zen_sin);
         end
      endcase
      unique case (sd.kind_az)
         TRIG_ZERO: begin
            ca_in = Q20_ONE;
            sa_in = '0;
         end
         TRIG_QUARTER: begin
            ca_in = '0;
            sa_in = Q20_ONE;
         end
         default: begin
            ca_in = mag20(az_cos);
            sa_in = mag20(az_sin);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= cv_ff[CORDIC_STEPS];
      end
      p1_side_ff <= sd;
      for (int i = 0; i < LANES; i++) begin
         p1_ang_ff[i] <= ang_in[i];
      end
      p1_cz_ff <= cz_in;
      p1_sz_ff <= sz_in;
      p1_ca_ff <= ca_in;
      p1_sa_ff <= sa_in;
   end

   // ---------------------------------------------------------------
   // post stage 2: azimuth against clamped corner angles
   logic signed [ANG_W-1:0] az, ga, gb, gc, gd;
   logic signed [ANG_W-1:0] xl_p1, xl_p2, xh_p1, xh_p2, yl_p1, yl_p2, yh_p1, yh_p2;
   logic                    rej_xl, rej_xh, rej_yl, rej_yh;
   tha_flags_type           flags_in;

   always_comb begin
      az = {{(ANG_W-16){p1_side_ff.azimuth[15]}}, p1_side_ff.azimuth};
      ga = p1_ang_ff[LANE_A];
      gb = p1_ang_ff[LANE_B];
      gc = p1_ang_ff[LANE_C];
      gd = p1_ang_ff[LANE_D];

      // outside -x
      xl_p1  = (ga < ANG_ZERO) ? ANG_ZERO : ga;
      xl_p2  = (gb > ANG_ZERO) ? ANG_ZERO : gb;
      rej_xl = (az > xl_p1) || (az < xl_p2);
      // outside +x: the wedge wraps through pi
      xh_p1  = (gc < ANG_ZERO) ? ANG_PI : gc;
      xh_p2  = (gd > ANG_ZERO) ? ANG_PI : gd;
      rej_xh = (az < xh_p1) && (az > xh_p2);
      // outside -y
      yl_p1  = (gd > ANG_HALFPI) ? ANG_HALFPI : gd;
      yl_p2  = (gb < ANG_HALFPI) ? ANG_HALFPI : gb;
      rej_yl = (az < yl_p1) || (az > yl_p2);
      // outside +y
      yh_p1  = (ga > ANG_NEG_HALFPI) ? ANG_NEG_HALFPI : ga;
      yh_p2  = (gc < ANG_NEG_HALFPI) ? ANG_NEG_HALFPI : gc;
      rej_yh = (az < yh_p1) || (az > yh_p2);

      flags_in.out_x = p1_side_ff.x_lo || p1_side_ff.x_hi;
      flags_in.out_y = p1_side_ff.y_lo || p1_side_ff.y_hi;
      flags_in.rej_x = p1_side_ff.x_lo ? rej_xl : rej_xh;
      flags_in.rej_y = p1_side_ff.y_lo ? rej_yl : rej_yh;
   end

   // reach test runs alongside, three stages
   logic steep_x, steep_y;

   tha_reach u_reach (
      .clock   (clock),
      .travel  (vtravel_ff),
      .sin_zen (p1_sz_ff),
      .cos_zen (p1_cz_ff),
      .cos_az  (p1_ca_ff),
      .sin_az  (p1_sa_ff),
      .dist_x  (p1_side_ff.dist_x),
      .dist_y  (p1_side_ff.dist_y),
      .steep_x (steep_x),
      .steep_y (steep_y)
   );

   // angle flags delayed to meet the reach result
   logic          q_vld_ff   [3];
   tha_flags_type q_flags_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            q_vld_ff[k] <= 1'b0;
         end
      end else begin
         q_vld_ff[0] <= p1_vld_ff;
         q_vld_ff[1] <= q_vld_ff[0];
         q_vld_ff[2] <= q_vld_ff[1];
      end
      q_flags_ff[0] <= flags_in;
      q_flags_ff[1] <= q_flags_ff[0];
      q_flags_ff[2] <= q_flags_ff[1];
   end

   // ---------------------------------------------------------------
   // final stage: first failing test in side order decides
   tha_cause_type cause_x, cause_y, cause_in;
   logic          rsp_strobe_ff;
   tha_rsp_type   rsp_word_ff;

   always_comb begin
      cause_x = CAUSE_ACCEPT;
      cause_y = CAUSE_ACCEPT;
      if (q_flags_ff[2].out_x) begin
         if (q_flags_ff[2].rej_x) begin
            cause_x = CAUSE_AZIMUTH;
         end else if (steep_x) begin
            cause_x = CAUSE_STEEP;
         end
      end
      if (q_flags_ff[2].out_y) begin
         if (q_flags_ff[2].rej_y) begin
            cause_y = CAUSE_AZIMUTH;
         end else if (steep_y) begin
            cause_y = CAUSE_STEEP;
         end
      end
      cause_in = (cause_x != CAUSE_ACCEPT) ? cause_x : cause_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= q_vld_ff[2];
      end
      rsp_word_ff.rejected     <= cause_in != CAUSE_ACCEPT;
      rsp_word_ff.reject_cause <= cause_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // ---------------------------------------------------------------
   // assertions
   a_strobe_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result word without a matching accepted word");

   a_flag_matches_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.rejected == (rsp_word.reject_cause != CAUSE_ACCEPT)))
      else $error("reject flag disagrees with cause");

   a_cause_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.reject_cause == CAUSE_ACCEPT ||
                      rsp_word.reject_cause == CAUSE_AZIMUTH ||
                      rsp_word.reject_cause == CAUSE_STEEP))
      else $error("illegal reject cause");

   a_one_x_side: assert property (@(posedge clock) disable iff (reset)
      p1_vld_ff |-> !(p1_side_ff.x_lo && p1_side_ff.x_hi))
      else $error("start point outside both x sides");

endmodule

// ===== bench/tb_track_hall_acceptance_check.sv =====
// Testbench for track_hall_acceptance_check: directed and random track words,
// register phases, and a scoreboard class with its own bit-exact predictor.
// Depends on tha_pkg and the block itself.
`timescale 1ns / 1ps
module tb_track_hall_acceptance_check;
   import tha_pkg::*;

   localparam longint HALF_TURN    = ANG_PI;
   localparam longint QUARTER_TURN = ANG_HALFPI;
   localparam longint NEG_QUARTER  = ANG_NEG_HALFPI;
   localparam longint UNIT_Q20     = Q20_ONE;
   localparam longint GAIN_Q30     = CORDIC_GAIN_INV;
   localparam longint LEN_MAX      = 8388607;
   localparam int     DRAIN_CYCLES = 40;

   // atan(2^-i) in 2^-32 turn
   localparam longint ARC_TURN32 [20] = '{
      536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087,
      667544, 333772, 166886, 83443, 41722,
      20861, 10430, 5215, 2608, 1304};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   tha_req_type req_word = '0;
   logic        rsp_strobe;
   tha_rsp_type rsp_word;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_X_HALF;
   logic [LEN_W-1:0] csr_wdata = '0;

   // predicted verdicts and their comparison
   class verdict_board;
      longint x_half, y_half, drop;
      tha_rsp_type pending_verdicts[$];
      int mismatches;

      function new();
         x_half = X_HALF_RESET;
         y_half = Y_HALF_RESET;
         drop = VTRAVEL_RESET;
         mismatches = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [LEN_W-1:0] val);
         case (idx)
            CSR_X_HALF:  x_half = val;
            CSR_Y_HALF:  y_half = val;
            CSR_VTRAVEL: drop = val;
            default: ;
         endcase
      endfunction

      function longint arc(longint dy, longint dx);
         longint x, y, z, base, xs, ys;
         z = 0;
         base = 0;
         if (dy == 0) return (dx < 0) ? HALF_TURN : 0;
         if (dx == 0) return (dy > 0) ? QUARTER_TURN : NEG_QUARTER;
         x = dx;
         y = dy;
         // fold into the right half plane
         if (dx < 0) begin
            if (dy > 0) begin
               x = dy; y = -dx; base = QUARTER_TURN;
            end else begin
               x = -dy; y = dx; base = NEG_QUARTER;
            end
         end
         x = x * 1048576;
         y = y * 1048576;
         for (int i = 0; i < 20; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x += ys; y -= xs; z += ARC_TURN32[i];
            end else begin
               x -= ys; y += xs; z -= ARC_TURN32[i];
            end
         end
         return ((z + 32768) >>> 16) + base;
      endfunction

      function longint q20_mag(longint q30);
         longint r;
         r = (q30 + 512) >>> 10;
         if (r < 0) r = -r;
         return (r > UNIT_Q20) ? UNIT_Q20 : r;
      endfunction

      // |cos| and |sin| in Q20
      function void cos_sin(longint a, output longint cm, output longint sm);
         longint x, y, z, xs, ys;
         if (a > QUARTER_TURN) a -= HALF_TURN;
         else if (a < NEG_QUARTER) a += HALF_TURN;
         if (a == 0) begin
            cm = UNIT_Q20; sm = 0; return;
         end
         if (a == QUARTER_TURN || a == NEG_QUARTER) begin
            cm = 0; sm = UNIT_Q20; return;
         end
         x = GAIN_Q30;
         y = 0;
         z = a * 65536;
         for (int i = 0; i < 20; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x -= ys; y += xs; z -= ARC_TURN32[i];
            end else begin
               x += ys; y -= xs; z += ARC_TURN32[i];
            end
         end
         cm = q20_mag(x);
         sm = q20_mag(y);
      endfunction

      // products wrap at 64 bits, unsigned
      function bit short_reach(longint sz, longint cz, longint d, longint c);
         logic [63:0] lhs, rhs;
         lhs = 64'(drop) * 64'(sz) * 64'(c);
         rhs = 64'(d) * 64'(cz) * 64'(UNIT_Q20);
         return lhs < rhs;
      endfunction

      function tha_cause_type judge(longint xp, longint yp, longint zen, longint az);
         longint p1, p2, sz, cz, ca, sa, xh, yh;
         xh = x_half;
         yh = y_half;
         if (zen > QUARTER_TURN) zen = QUARTER_TURN;
         cos_sin(zen, cz, sz);
         cos_sin(az, ca, sa);
         if (xp < -xh) begin
            p1 = arc(yh - yp, -xh - xp);
            if (p1 < 0) p1 = 0;
            if (az > p1) return CAUSE_AZIMUTH;
            p2 = arc(-yh - yp, -xh - xp);
            if (p2 > 0) p2 = 0;
            if (az < p2) return CAUSE_AZIMUTH;
            if (short_reach(sz, cz, -xh - xp, ca)) return CAUSE_STEEP;
         end
         if (xp > xh) begin
            p1 = arc(yh - yp, xh - xp);
            if (p1 < 0) p1 = HALF_TURN;
            p2 = arc(-yh - yp, xh - xp);
            if (p2 > 0) p2 = HALF_TURN;
            if (az < p1 && az > p2) return CAUSE_AZIMUTH;
            if (short_reach(sz, cz, xp - xh, ca)) return CAUSE_STEEP;
         end
         if (yp < -yh) begin
            p1 = arc(-yh - yp, xh - xp);
            if (p1 > QUARTER_TURN) p1 = QUARTER_TURN;
            if (az < p1) return CAUSE_AZIMUTH;
            p2 = arc(-yh - yp, -xh - xp);
            if (p2 < QUARTER_TURN) p2 = QUARTER_TURN;
            if (az > p2) return CAUSE_AZIMUTH;
            if (short_reach(sz, cz, -yh - yp, sa)) return CAUSE_STEEP;
         end
         if (yp > yh) begin
            p1 = arc(yh - yp, -xh - xp);
            if (p1 > NEG_QUARTER) p1 = NEG_QUARTER;
            if (az < p1) return CAUSE_AZIMUTH;
            p2 = arc(yh - yp, xh - xp);
            if (p2 < NEG_QUARTER) p2 = NEG_QUARTER;
            if (az > p2) return CAUSE_AZIMUTH;
            if (short_reach(sz, cz, yp - yh, sa)) return CAUSE_STEEP;
         end
         return CAUSE_ACCEPT;
      endfunction

      function void note_track(tha_req_type w);
         tha_rsp_type v;
         v.reject_cause = judge(longint'(w.x_position), longint'(w.y_position),
                                longint'(w.zenith), longint'(w.azimuth));
         v.rejected = (v.reject_cause != CAUSE_ACCEPT);
         pending_verdicts.push_back(v);
      endfunction

      function void check_verdict(tha_rsp_type got);
         tha_rsp_type want;
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: rejected %0d cause %0d",
                        got.rejected, got.reject_cause);
            return;
         end
         want = pending_verdicts.pop_front();
         if (got.rejected !== want.rejected || got.reject_cause !== want.reject_cause) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: expected rejected %0d cause %0d, got %0d %0d",
                        want.rejected, want.reject_cause, got.rejected, got.reject_cause);
         end
      endfunction
   endclass

   verdict_board board = new();

   track_hall_acceptance_check i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata));

   always #2 clock = ~clock;

   // monitors: accepted words, register writes, result words
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_track(req_word);
         if (csr_valid && csr_ready) board.set_reg(csr_index, csr_wdata);
         if (rsp_strobe) board.check_verdict(rsp_word);
      end
   end

   // one track word; start stays high if the caller sends again at once
   task automatic send_track(longint xp, longint yp, longint zen, longint az);
      start <= 1'b1;
      req_word.x_position <= 24'(xp);
      req_word.y_position <= 24'(yp);
      req_word.zenith <= 15'(zen);
      req_word.azimuth <= 16'(az);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_gap();
      int n;
      n = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // stop sending, wait until drained, then write one register
   task automatic write_reg(logic [1:0] idx, longint val);
      start <= 1'b0;
      @(posedge clock);
      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= LEN_W'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_region(longint xh, longint yh, longint dv);
      write_reg(CSR_X_HALF, xh);
      write_reg(CSR_Y_HALF, yh);
      write_reg(CSR_VTRAVEL, dv);
   endtask

   function automatic longint pick_angle();
      case ($urandom_range(0, 9))
         0: return -32768;
         1: return 0;
         2: return 16384;
         3: return -16384;
         4: return 32767;
         default: return longint'($signed(16'($urandom())));
      endcase
   endfunction

   function automatic longint pick_zenith();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 16384;
         2: return $urandom_range(16385, 32767);
         default: return $urandom_range(0, 16384);
      endcase
   endfunction

   // coordinate near the region edge, or anywhere at all
   function automatic longint pick_coord(longint half);
      longint span;
      if ($urandom_range(0, 4) == 0) return longint'($signed(24'($urandom())));
      if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) ? half : -half);
      span = 3 * half + 2000;
      return longint'($urandom_range(0, 32'(2 * span))) - span;
   endfunction

   // random stream in bursts
   task automatic random_tracks(int count);
      int left;
      left = count;
      while (left > 0) begin
         int burst;
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && left > 0; k++) begin
            send_track(pick_coord(board.x_half), pick_coord(board.y_half),
                       pick_zenith(), pick_angle());
            left--;
         end
         if ($urandom_range(0, 3) != 0) idle_gap();
      end
      start <= 1'b0;
   endtask

   initial begin
      longint h;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, all sides, corners, axes, horizontal
      h = 12000;
      send_track(0, 0, 0, 0);
      send_track(-8388608, -8388608, 0, -32768);
      send_track(8388607, 8388607, 32767, 32767);
      send_track(-20000, 0, 8000, 0);
      send_track(-20000, 0, 8000, 32767);
      send_track(20000, 0, 8000, -32768);
      send_track(20000, 0, 8000, 0);
      send_track(0, -20000, 8000, 16384);
      send_track(0, -20000, 8000, -16384);
      send_track(0, 20000, 8000, -16384);
      send_track(0, 20000, 100, -16384);
      send_track(-20000, -20000, 12000, 8192);
      send_track(20000, 20000, 12000, -24576);
      send_track(-20000, 20000, 16384, -8192);
      send_track(20000, -20000, 20000, 24576);
      send_track(-h - 1, h, 9000, 0);
      send_track(h + 1, -h, 9000, -32768);
      send_track(0, -h - 5, 16384, 16384);
      send_track(-30000, 0, 16384, 16384);
      send_track(0, 30000, 5000, 0);
      idle_gap();

      set_region(0, 0, 0);
      send_track(1, 1, 16384, -24576);
      send_track(-1, 0, 16384, 0);
      send_track(0, -1, 0, 16384);
      set_region(LEN_MAX, LEN_MAX, LEN_MAX);
      send_track(-8388608, -8388608, 16383, 8192);
      send_track(-8388608, 0, 1, 0);
      send_track(0, -8388608, 16384, 16384);
      start <= 1'b0;

      // random phases over several region settings
      set_region(X_HALF_RESET, Y_HALF_RESET, VTRAVEL_RESET);
      random_tracks(250);
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_region(0, 0, LEN_MAX);
            1: set_region(LEN_MAX, LEN_MAX, 0);
            2: set_region($urandom_range(0, 30000), $urandom_range(0, 30000),
                          $urandom_range(0, 40000));
            3: set_region($urandom_range(0, LEN_MAX), $urandom_range(0, LEN_MAX),
                          $urandom_range(0, LEN_MAX));
            4: set_region($urandom_range(1, 500), $urandom_range(1, 500),
                          $urandom_range(100, 5000));
            default: set_region(5000, 40000, 19000);
         endcase
         random_tracks(190);
      end

      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending_verdicts.size() == 0) begin
         $display("tb_track_hall_acceptance_check: PASS");
      end else begin
         $display("tb_track_hall_acceptance_check: FAIL");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #2000000;
      $display("tb_track_hall_acceptance_check: FAIL");
      $finish;
   end

endmodule

// ===== track_hall_acceptance_check.f =====
sv/tha_pkg.sv
sv/tha_vec_pipe.sv
sv/tha_rot_pipe.sv
sv/tha_reach.sv
sv/track_hall_acceptance_check.sv
bench/tb_track_hall_acceptance_check.sv
